// ----- rtl/core/svw_pkg.sv -----
// Shared types and constants for the serial variable write decoder.
// Depends on nothing; imported by the parser and the core top level.
package svw_pkg;

	localparam int WORD_W = 32;
	localparam int SIZE_W = 3;
	localparam int TAG_W  = 5;

	// Number of low bytes replaced by one write packet.
	localparam logic [SIZE_W-1:0] SIZE_1 = 3'd1;
	localparam logic [SIZE_W-1:0] SIZE_2 = 3'd2;
	localparam logic [SIZE_W-1:0] SIZE_4 = 3'd4;

	// Write request handed from the parser to the read-modify-write stage.
	typedef struct packed {
		logic              fire;
		logic [SIZE_W-1:0] size;
		logic [WORD_W-1:0] data;
	} svw_req_t;

	function automatic logic [WORD_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
		logic [WORD_W-1:0] m;
		case (size)
			SIZE_1:  m = 32'h0000_00FF;
			SIZE_2:  m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/core/svw_store.sv -----
// Variable store: one synchronous memory with a registered read port and
// per-entry valid bits so that unwritten entries read with rd_hit low after reset.
module svw_store #(
	parameter int VAR_COUNT = 16,
	parameter int IDX_W     = 4,
	parameter int DATA_W    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data,
	output logic              rd_hit,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0]    mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] vld_q;
	logic [DATA_W-1:0]    rd_data_q;
	logic                 rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

// ----- rtl/core/svw_parser.sv -----
// Byte parser: hunts for headers, checks the index and length, and gathers
// data bytes. Depends on svw_pkg for the request type and size codes.
module svw_parser import svw_pkg::*; #(
	parameter int VAR_COUNT = 16,
	parameter int IDX_W     = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TAG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             hold,
	output svw_req_t         req,
	output logic [IDX_W-1:0] req_idx
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_INDEX,
		PH_DATA
	} phase_t;

	phase_t            phase_q;
	logic [SIZE_W-1:0] left_q;
	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [WORD_W-1:0] acc_q;
	logic [TAG_W-1:0]  tag_q;

	logic              accept;
	logic              last;
	logic [WORD_W-1:0] acc_nx;
	logic [SIZE_W-1:0] rest;
	logic              idx_ok;
	logic              size_ok;

	assign last     = (phase_q == PH_DATA) && (left_q == 3'd1);
	// The final byte of a packet waits while the previous write is still pending.
	assign in_stall = last && hold;
	assign accept   = in_valid && !in_stall;
	assign acc_nx   = {acc_q[WORD_W-9:0], rx_byte};
	assign rest     = left_q - 3'd1;
	assign idx_ok   = (rx_byte != 8'd0) && ({1'b0, rx_byte} < 9'(VAR_COUNT));
	assign size_ok  = (rest == SIZE_1) || (rest == SIZE_2) || (rest == SIZE_4);

	assign req.fire = accept && last;
	assign req.size = size_q;
	assign req.data = acc_nx;
	assign req_idx  = tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= '0;
			size_q  <= '0;
			tgt_q   <= '0;
			acc_q   <= '0;
			tag_q   <= '0;
		end else begin
			if (cfg_we) begin
				tag_q <= cfg_wdata;
			end
			if (accept) begin
				case (phase_q)
					PH_HUNT: begin
						if ((rx_byte[7:3] == tag_q) && (rx_byte[2:0] != 3'd0)) begin
							left_q  <= rx_byte[2:0];
							phase_q <= PH_INDEX;
						end
					end
					PH_INDEX: begin
						if (idx_ok && size_ok) begin
							tgt_q   <= rx_byte[IDX_W-1:0];
							left_q  <= rest;
							size_q  <= rest;
							acc_q   <= '0;
							phase_q <= PH_DATA;
						end else begin
							left_q  <= '0;
							phase_q <= PH_HUNT;
						end
					end
					PH_DATA: begin
						left_q <= left_q - 3'd1;
						if (last) begin
							acc_q   <= '0;
							phase_q <= PH_HUNT;
						end else begin
							acc_q <= acc_nx;
						end
					end
					default: begin
						left_q  <= '0;
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/serial_variable_write_decoder_core.sv -----
// Two register stages, the store read with the s1 registers and then the output
// registers, lie between the edge that takes the last data byte and the result word.
// Throughput: one input byte per cycle; the last byte of a packet waits only
// while the previous packet's read-modify-write of the store is still held.
// Reset clears the parser, the header tag and the store's valid bits, so every
// variable reads as zero at once; no clearing pass is needed.
module serial_variable_write_decoder_core import svw_pkg::*; #(
	parameter int VAR_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TAG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        var_index,
	output logic [WORD_W-1:0] new_value,
	output logic [SIZE_W-1:0] bytes_written
);

	localparam int IDX_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	svw_req_t          req;
	logic [IDX_W-1:0]  req_idx;
	logic [WORD_W-1:0] rd_data;
	logic              rd_hit;

	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WORD_W-1:0] data_s1;
	logic [SIZE_W-1:0] size_s1;

	logic              out_valid_q;
	logic [3:0]        var_index_q;
	logic [WORD_W-1:0] new_value_q;
	logic [SIZE_W-1:0] bytes_written_q;

	logic              advance;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] merged;
	logic [IDX_W+3:0]  idx_ext;

	svw_parser #(
		.VAR_COUNT(VAR_COUNT),
		.IDX_W    (IDX_W)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.hold     (valid_s1),
		.req      (req),
		.req_idx  (req_idx)
	);

	svw_store #(
		.VAR_COUNT(VAR_COUNT),
		.IDX_W    (IDX_W),
		.DATA_W   (WORD_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (req.fire),
		.rd_addr(req_idx),
		.rd_data(rd_data),
		.rd_hit (rd_hit),
		.wr_en  (advance),
		.wr_addr(idx_s1),
		.wr_data(merged)
	);

	// The store read issued with the last byte lands here in the following cycle; a new
	// read cannot start until this write-back has gone, so no forwarding is needed.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign base    = rd_hit ? rd_data : '0;
	assign mask    = size_mask(size_s1);
	assign merged  = (base & ~mask) | (data_s1 & mask);
	assign idx_ext = {4'd0, idx_s1};

	always_ff @(posedge clk) begin
		if (req.fire) begin
			idx_s1  <= req_idx;
			data_s1 <= req.data;
			size_s1 <= req.size;
		end
		if (advance) begin
			var_index_q     <= idx_ext[3:0];
			new_value_q     <= merged;
			bytes_written_q <= size_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign var_index     = var_index_q;
	assign new_value     = new_value_q;
	assign bytes_written = bytes_written_q;

endmodule
